// File: src/greedy_two_way_partition_unit_macros.svh
// Assertion macros shared by the partition unit.
`ifndef GREEDY_TWO_WAY_PARTITION_UNIT_MACROS_SVH
`define GREEDY_TWO_WAY_PARTITION_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// The condition holds at every clock edge out of reset.
`define GTWP_ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("gtwp assertion failed");

// The consequent holds in the same cycle as the antecedent.
`define GTWP_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("gtwp assertion failed");

// The consequent holds in the cycle after the antecedent.
`define GTWP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("gtwp assertion failed");

`else

`define GTWP_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define GTWP_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define GTWP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: src/gtwp_pkg.sv
package gtwp_pkg;

	// Field widths fixed by the item formats.
	localparam int VAL_W = 16;
	localparam int SUM_W = 22;

	// Default capacity of the sorting chain.
	localparam int MAX_ITEMS_DEF = 64;

	// Commands broadcast to every cell of the chain.
	typedef struct packed {
		logic insert;
		logic shift;
	} cell_ctrl_t;

	// Commands from the sequencer to the accumulator.
	typedef struct packed {
		logic pop;
		logic last;
		logic drop;
	} acc_ctrl_t;

endpackage

// File: src/gtwp_if.sv
// Input channel: one value word per handshake.
interface gtwp_in_if;
	logic                        valid;
	logic                        ready;
	logic [gtwp_pkg::VAL_W-1:0]  item_value;
	logic                        last_item;

	modport source (output valid, output item_value, output last_item, input ready);
	modport sink (input valid, input item_value, input last_item, output ready);
endinterface

// Output channel: one partition result word per handshake.
interface gtwp_out_if;
	logic                        valid;
	logic                        ready;
	logic [gtwp_pkg::VAL_W-1:0]  sorted_value;
	logic                        owner;
	logic [gtwp_pkg::SUM_W-1:0]  first_sum;
	logic [gtwp_pkg::SUM_W-1:0]  second_sum;
	logic [gtwp_pkg::SUM_W-1:0]  sum_gap;
	logic                        overflowed;
	logic                        final_result;

	modport source (output valid, output sorted_value, output owner, output first_sum,
		output second_sum, output sum_gap, output overflowed, output final_result,
		input ready);
	modport sink (input valid, input sorted_value, input owner, input first_sum,
		input second_sum, input sum_gap, input overflowed, input final_result,
		output ready);
endinterface

// File: src/greedy_two_way_partition_unit.sv
// Greedy two-way partition unit. Values arrive one word per cycle and are sorted on the fly
// into a chain of MAX_ITEMS cells, largest at the head; words beyond capacity are dropped and
// the set is marked as overflowed. The word flagged last closes the set (it is stored too if
// there is room). The input then stalls while the chain shifts its contents out through the
// head, one value per cycle whenever the output register is free or being read; each value
// goes to the first group only if that group's total is strictly below the second's, and
// each produces one result word with both totals and their gap. The output is
// registered, and the next set may start loading as soon as the final result is registered.
`include "greedy_two_way_partition_unit_macros.svh"

module greedy_two_way_partition_unit #(
	parameter int MAX_ITEMS = gtwp_pkg::MAX_ITEMS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	gtwp_in_if.sink    in_ch,
	gtwp_out_if.source out_ch
);

	localparam int CNT_W = $clog2(MAX_ITEMS + 1);

	typedef enum logic [1:0] {
		ST_LOAD  = 2'b01,
		ST_DRAIN = 2'b10
	} state_t;

	state_t               state_q;
	logic [CNT_W-1:0]     count_q;
	logic                 drop_q;
	logic                 accept;
	logic                 full;
	logic                 can_take;
	logic                 pop;
	logic                 pop_last;
	gtwp_pkg::cell_ctrl_t cell_ctrl;
	gtwp_pkg::acc_ctrl_t  acc_ctrl;

	logic                       cell_keep  [MAX_ITEMS];
	logic                       cell_valid [MAX_ITEMS];
	logic [gtwp_pkg::VAL_W-1:0] cell_value [MAX_ITEMS];

	// Handshake and sequencing strobes.
	assign in_ch.ready = (state_q == ST_LOAD);
	assign accept      = in_ch.valid && in_ch.ready;
	assign full        = (count_q == CNT_W'(MAX_ITEMS));
	assign pop         = (state_q == ST_DRAIN) && can_take;
	assign pop_last    = pop && (count_q == CNT_W'(1));

	assign cell_ctrl.insert = accept && !full;
	assign cell_ctrl.shift  = pop;
	assign acc_ctrl.pop     = pop;
	assign acc_ctrl.last    = pop_last;
	assign acc_ctrl.drop    = drop_q;

	// Sequencer: the count tracks stored values while loading and remaining ones while draining.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			drop_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (full) begin
							drop_q <= 1'b1;
						end else begin
							count_q <= count_q + CNT_W'(1);
						end
						if (in_ch.last_item) begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					if (pop) begin
						count_q <= count_q - CNT_W'(1);
						if (pop_last) begin
							drop_q  <= 1'b0;
							state_q <= ST_LOAD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// Insertion chain; the head sees an always-larger neighbor, the tail an empty one.
	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		logic                       prev_keep;
		logic                       prev_valid;
		logic [gtwp_pkg::VAL_W-1:0] prev_value;
		logic                       next_valid;
		logic [gtwp_pkg::VAL_W-1:0] next_value;

		if (i == 0) begin : g_head
			assign prev_keep  = 1'b1;
			assign prev_valid = 1'b1;
			assign prev_value = '0;
		end else begin : g_body
			assign prev_keep  = cell_keep[i-1];
			assign prev_valid = cell_valid[i-1];
			assign prev_value = cell_value[i-1];
		end

		if (i == MAX_ITEMS - 1) begin : g_tail
			assign next_valid = 1'b0;
			assign next_value = '0;
		end else begin : g_inner
			assign next_valid = cell_valid[i+1];
			assign next_value = cell_value[i+1];
		end

		gtwp_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (cell_ctrl),
			.ins_value  (in_ch.item_value),
			.prev_keep  (prev_keep),
			.prev_valid (prev_valid),
			.prev_value (prev_value),
			.next_valid (next_valid),
			.next_value (next_value),
			.keep       (cell_keep[i]),
			.valid      (cell_valid[i]),
			.value      (cell_value[i])
		);
	end

	// Totals and output register.
	gtwp_accum u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (acc_ctrl),
		.head_value (cell_value[0]),
		.can_take   (can_take),
		.out_ch     (out_ch)
	);

	// The stored count never exceeds the chain length.
	`GTWP_ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CNT_W'(MAX_ITEMS))
	// While draining, the head cell always holds a value.
	`GTWP_ASSERT_IMPLIES(a_head_valid, clk, arst_n, state_q == ST_DRAIN, cell_valid[0])
	// An empty chain shows an empty head.
	`GTWP_ASSERT_IMPLIES(a_empty_head, clk, arst_n, count_q == '0, !cell_valid[0])
	// The final pop returns the block to loading with a cleared count.
	`GTWP_ASSERT_NEXT(a_last_pop, clk, arst_n, pop_last,
		(state_q == ST_LOAD) && (count_q == '0) && !drop_q)

endmodule

// File: src/gtwp_cell.sv
// One slot of the descending insertion chain.
module gtwp_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  gtwp_pkg::cell_ctrl_t       ctrl,
	input  logic [gtwp_pkg::VAL_W-1:0] ins_value,
	input  logic                       prev_keep,
	input  logic                       prev_valid,
	input  logic [gtwp_pkg::VAL_W-1:0] prev_value,
	input  logic                       next_valid,
	input  logic [gtwp_pkg::VAL_W-1:0] next_value,
	output logic                       keep,
	output logic                       valid,
	output logic [gtwp_pkg::VAL_W-1:0] value
);

	logic                       valid_q;
	logic [gtwp_pkg::VAL_W-1:0] value_q;

	// The cell keeps its value when it already holds one at least as large as the new word.
	assign keep  = valid_q && (value_q >= ins_value);
	assign valid = valid_q;
	assign value = value_q;

	// Occupancy moves with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= next_valid;
		end else if (ctrl.insert && !keep) begin
			valid_q <= prev_keep ? 1'b1 : prev_valid;
		end
	end

	// On insert the new word lands right after the last value at least as large; the rest move down.
	// On shift every value moves one place toward the head.
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			value_q <= next_value;
		end else if (ctrl.insert && !keep) begin
			value_q <= prev_keep ? ins_value : prev_value;
		end
	end

endmodule

// File: src/gtwp_accum.sv
// Greedy assignment of the head value and the registered result word.
module gtwp_accum (
	input  logic                       clk,
	input  logic                       arst_n,
	input  gtwp_pkg::acc_ctrl_t        ctrl,
	input  logic [gtwp_pkg::VAL_W-1:0] head_value,
	output logic                       can_take,
	gtwp_out_if.source                 out_ch
);

	logic [gtwp_pkg::SUM_W-1:0] first_q;
	logic [gtwp_pkg::SUM_W-1:0] second_q;
	logic [gtwp_pkg::SUM_W-1:0] ext_value;
	logic [gtwp_pkg::SUM_W-1:0] first_nx;
	logic [gtwp_pkg::SUM_W-1:0] second_nx;
	logic [gtwp_pkg::SUM_W-1:0] gap_nx;
	logic                       to_first;
	logic                       valid_q;

	// The output register frees up when its word is taken.
	assign can_take = !valid_q || out_ch.ready;

	// The first group wins only when strictly behind; ties go to the second group.
	always_comb begin
		ext_value = gtwp_pkg::SUM_W'(head_value);
		to_first  = first_q < second_q;
		first_nx  = to_first ? first_q + ext_value : first_q;
		second_nx = to_first ? second_q : second_q + ext_value;
		gap_nx    = (first_nx >= second_nx) ? first_nx - second_nx : second_nx - first_nx;
	end

	// Running totals restart after the last value of a set.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q  <= '0;
			second_q <= '0;
		end else if (ctrl.pop) begin
			first_q  <= ctrl.last ? '0 : first_nx;
			second_q <= ctrl.last ? '0 : second_nx;
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.pop) begin
			valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (ctrl.pop) begin
			out_ch.sorted_value <= head_value;
			out_ch.owner        <= !to_first;
			out_ch.first_sum    <= first_nx;
			out_ch.second_sum   <= second_nx;
			out_ch.sum_gap      <= gap_nx;
			out_ch.overflowed   <= ctrl.drop;
			out_ch.final_result <= ctrl.last;
		end
	end

	assign out_ch.valid = valid_q;

endmodule

// File: dv/tb_greedy_two_way_partition_unit.sv
module tb_greedy_two_way_partition_unit;

	localparam int VAL_W = gtwp_pkg::VAL_W;
	localparam int SUM_W = gtwp_pkg::SUM_W;
	localparam int CAPACITY = gtwp_pkg::MAX_ITEMS_DEF;
	localparam int WORD_TARGET = 470;
	localparam int HOLD_AFTER = 120;
	localparam int HOLD_CYCLES = 400;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 2 * CAPACITY + 16;

	// Value patterns used to fill a random set.
	typedef enum int {
		MIX_ANY,
		MIX_TIES,
		MIX_EXTREMES,
		MIX_PEAK
	} value_mix_t;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic             closes;
	} stim_word_t;

	typedef struct packed {
		logic [VAL_W-1:0] sorted_value;
		logic             owner;
		logic [SUM_W-1:0] first_sum;
		logic [SUM_W-1:0] second_sum;
		logic [SUM_W-1:0] sum_gap;
		logic             overflowed;
		logic             final_result;
	} split_word_t;

	// Keeps the values of the open set in descending order and, when the set
	// closes, deals them out greedily to two groups to form the expected words.
	class partition_scoreboard;
		int               capacity;
		logic [VAL_W-1:0] held[$];
		logic             dropped;
		split_word_t      pending[$];
		int unsigned      failures;

		function new(int cap);
			capacity = cap;
			dropped = 1'b0;
			failures = 0;
		endfunction

		function void note_word(logic [VAL_W-1:0] value, logic closes);
			int          pos;
			logic [SUM_W-1:0] tally0;
			logic [SUM_W-1:0] tally1;
			split_word_t w;
			if (held.size() < capacity) begin
				pos = held.size();
				while (pos > 0 && held[pos-1] < value)
					pos--;
				held.insert(pos, value);
			end else begin
				dropped = 1'b1;
			end
			if (!closes)
				return;
			tally0 = '0;
			tally1 = '0;
			foreach (held[k]) begin
				// Ties go to the second group.
				if (tally0 < tally1) begin
					w.owner = 1'b0;
					tally0 = tally0 + held[k];
				end else begin
					w.owner = 1'b1;
					tally1 = tally1 + held[k];
				end
				w.sorted_value = held[k];
				w.first_sum = tally0;
				w.second_sum = tally1;
				w.sum_gap = (tally0 >= tally1) ? tally0 - tally1 : tally1 - tally0;
				w.overflowed = dropped;
				w.final_result = (k == held.size() - 1);
				pending.push_back(w);
			end
			held.delete();
			dropped = 1'b0;
		endfunction

		function void compare_field(string field, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, actual %0d", field, want, got);
				failures++;
			end
		endfunction

		function void check_result(split_word_t got);
			split_word_t want;
			if (pending.size() == 0) begin
				$error("result word with no expected word waiting");
				failures++;
				return;
			end
			want = pending.pop_front();
			compare_field("sorted_value", want.sorted_value, got.sorted_value);
			compare_field("owner", want.owner, got.owner);
			compare_field("first_sum", want.first_sum, got.first_sum);
			compare_field("second_sum", want.second_sum, got.second_sum);
			compare_field("sum_gap", want.sum_gap, got.sum_gap);
			compare_field("overflowed", want.overflowed, got.overflowed);
			compare_field("final_result", want.final_result, got.final_result);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	gtwp_in_if  in_ch();
	gtwp_out_if out_ch();

	greedy_two_way_partition_unit #(
		.MAX_ITEMS(CAPACITY)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	partition_scoreboard book;
	stim_word_t          stimulus[$];
	int unsigned         results_seen = 0;
	int unsigned         stall_cycles = 0;
	logic                wind_down = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Queue one set of words; the last one closes the set.
	function automatic void queue_listed(input logic [VAL_W-1:0] vals[$]);
		stim_word_t w;
		foreach (vals[k]) begin
			w.value = vals[k];
			w.closes = (k == vals.size() - 1);
			stimulus.push_back(w);
		end
	endfunction

	function automatic void queue_random_set(int unsigned size, value_mix_t mix);
		logic [VAL_W-1:0] vals[$];
		for (int unsigned k = 0; k < size; k++) begin
			case (mix)
				MIX_TIES: begin
					vals.push_back(VAL_W'($urandom_range(0, 3)));
				end
				MIX_EXTREMES: begin
					vals.push_back($urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
				end
				MIX_PEAK: begin
					vals.push_back(16'hFFFF);
				end
				default: begin
					vals.push_back(VAL_W'($urandom_range(0, 65535)));
				end
			endcase
		end
		queue_listed(vals);
	endfunction

	// Directed sets first, then an overflowing set at full scale, then random sets
	// that are mostly small with the odd full or overflowing one.
	function automatic void build_stimulus();
		int unsigned pick;
		int unsigned size;
		value_mix_t  mix;
		queue_listed('{16'hFFFF});
		queue_listed('{16'h0000});
		queue_listed('{16'd7, 16'd7, 16'd7, 16'd7});
		queue_listed('{16'h0000, 16'hFFFF, 16'd1, 16'h8000, 16'hFFFE, 16'd2, 16'd100,
			16'd100});
		queue_listed('{16'd3, 16'd1, 16'd4, 16'd1, 16'd5, 16'd9, 16'd2, 16'd6});
		queue_listed('{16'hFFFF, 16'hFFFF, 16'h0000});
		queue_random_set(CAPACITY + 4, MIX_PEAK);
		while (stimulus.size() < WORD_TARGET) begin
			pick = $urandom_range(0, 24);
			if (pick == 0)
				size = $urandom_range(CAPACITY + 1, CAPACITY + 6);
			else if (pick == 1)
				size = CAPACITY;
			else if (pick < 5)
				size = 1;
			else
				size = $urandom_range(2, 12);
			pick = $urandom_range(0, 9);
			if (pick < 6)
				mix = MIX_ANY;
			else if (pick < 8)
				mix = MIX_TIES;
			else
				mix = MIX_EXTREMES;
			queue_random_set(size, mix);
		end
	endfunction

	task automatic offer_word(stim_word_t w);
		in_ch.valid <= 1'b1;
		in_ch.item_value <= w.value;
		in_ch.last_item <= w.closes;
		do
			@(posedge clk);
		while (in_ch.ready !== 1'b1);
	endtask

	task automatic pause_source(int unsigned cycles);
		in_ch.valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Note accepted input words before checking result words of the same edge.
	always @(posedge clk) begin
		if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
			book.note_word(in_ch.item_value, in_ch.last_item);
		if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			book.check_result('{sorted_value: out_ch.sorted_value, owner: out_ch.owner,
				first_sum: out_ch.first_sum, second_sum: out_ch.second_sum,
				sum_gap: out_ch.sum_gap, overflowed: out_ch.overflowed,
				final_result: out_ch.final_result});
			results_seen <= results_seen + 1;
		end
	end

	// Watchdog on cycles in which neither channel moves a word.
	always @(posedge clk) begin
		if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
			(out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("greedy_two_way_partition_unit: mismatch");
			$finish;
		end
	end

	// Result sink: random stalls, one long hold-off to back the block up, and a
	// steady ready once the source is in its last stretch.
	initial begin : result_sink
		logic held_off;
		held_off = 1'b0;
		out_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (!held_off && results_seen >= HOLD_AFTER) begin
				held_off = 1'b1;
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!wind_down && $urandom_range(0, 4) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end else begin
				out_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	// Word source and end of run.
	initial begin : word_source
		int unsigned calm_left;
		int unsigned tail_start;
		calm_left = 0;
		book = new(CAPACITY);
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.item_value <= '0;
		in_ch.last_item <= 1'b0;
		build_stimulus();
		tail_start = stimulus.size() * 85 / 100;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (stimulus[i]) begin
			if (i >= tail_start) begin
				wind_down <= 1'b1;
			end else if (calm_left > 0) begin
				calm_left--;
			end else if ($urandom_range(0, 15) == 0) begin
				calm_left = $urandom_range(20, 60);
			end else if ($urandom_range(0, 3) == 0) begin
				pause_source($urandom_range(1, 16));
			end
			offer_word(stimulus[i]);
		end
		in_ch.valid <= 1'b0;
		// Let the sampling process note the closing word before looking at the queue.
		@(posedge clk);
		while (book.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (book.pending.size() != 0) begin
			$error("%0d expected result words never arrived", book.pending.size());
			book.failures++;
		end
		if (book.failures == 0) begin
			$display("greedy_two_way_partition_unit: match");
		end else begin
			$display("greedy_two_way_partition_unit: mismatch");
		end
		$finish;
	end

endmodule
